[hw/rtl/tccs_pkg.sv]
// shared types and constants of the text console with cursor and scroll
package tccs_pkg;

   localparam int TCCS_COLS     = 80;
   localparam int TCCS_ROWS     = 25;
   localparam int TCCS_TAB_STOP = 8;

   localparam int REQ_W = 24;
   localparam int RSP_W = 40;

   localparam logic [7:0] ATTR_RESET = 8'h07;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EXEC  = 8'b0000_0010,
      ST_TAB   = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_COPY  = 8'b0001_0000,
      ST_DRAIN = 8'b0010_0000,
      ST_FILL  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage

[hw/rtl/text_console_cursor_scroll_top.sv]
// sequencer: a put goes through EXEC (and TAB for a tab), a read through READ, unused mode to DONE
// a tab steps through TAB by TAB_STOP until past the cursor column; a scroll copies cells up in
// COPY, then DRAIN and a blank fill of the bottom row in FILL; a clear fills every cell in FILL
// one request at a time: the next is accepted the cycle after the response is loaded, and
// DONE holds the response back until the response register is free
// reset: synchronous, cursor homed, attribute 7, response empty; cell contents undefined
module text_console_cursor_scroll_top
   import tccs_pkg::*;
#(
   parameter int COLS     = TCCS_COLS,
   parameter int ROWS     = TCCS_ROWS,
   parameter int TAB_STOP = TCCS_TAB_STOP
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // mode[1:0], char_code[9:2], cell_index[20:10], zero fill
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // cursor_pos[10:0], cursor_row[15:11], cursor_col[22:16], cell_data[38:23], scrolled[39]
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam int CELLS     = ROWS * COLS;
   localparam int AW        = $clog2(CELLS);
   localparam int RW        = $clog2(ROWS + 1);
   localparam int CW        = $clog2(COLS + TAB_STOP);
   localparam int COPY_LAST = (ROWS - 1) * COLS - 1;
   localparam int LAST_BASE = (ROWS - 1) * COLS;

   state_type        state_ff, state_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [7:0]       attr_ff, attr_in;
   mode_type         mode_ff, mode_in;
   logic [7:0]       char_ff, char_in;
   logic [10:0]      idx_ff, idx_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [AW-1:0]    cnt_ff, cnt_in;
   logic             cp_vld_ff, cp_vld_in;
   logic [AW-1:0]    cp_addr_ff, cp_addr_in;
   logic             scrolled_ff, scrolled_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [15:0]      rd_data_ff;

   logic [15:0]      mem [CELLS];
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [15:0]      mem_wd;
   logic [AW-1:0]    mem_ra;

   logic [RW-1:0]    fx_row, wr_row;
   logic [CW-1:0]    fx_col, wr_col;
   logic             fx_done;
   logic [15:0]      out_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // cursor move of the current character, then wrap to the next row
   always_comb begin
      fx_row  = row_ff;
      fx_col  = col_ff;
      fx_done = 1'b1;
      if (state_ff == ST_TAB) begin
         fx_col  = acc_ff;
         fx_done = (acc_ff > col_ff);
      end else begin
         case (char_ff)
            CH_BS: begin
               if (col_ff != '0) fx_col = col_ff - 1'b1;
            end
            CH_TAB: fx_done = 1'b0;
            CH_CR: fx_col = '0;
            CH_LF: begin
               fx_col = '0;
               fx_row = row_ff + 1'b1;
            end
            default: begin
               if (char_ff >= CH_SPACE) fx_col = col_ff + 1'b1;
            end
         endcase
      end
      wr_row = fx_row;
      wr_col = fx_col;
      if (32'(fx_col) >= COLS) begin
         wr_col = '0;
         wr_row = fx_row + 1'b1;
      end
   end

   always_comb begin
      out_data = '0;
      if (mode_ff == MODE_READ && 32'(idx_ff) < CELLS) out_data = rd_data_ff;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      attr_in      = attr_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      cp_vld_in    = 1'b0;
      cp_addr_in   = cp_addr_ff;
      scrolled_in  = scrolled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff;
      mem_wd       = {attr_ff, CH_SPACE};
      mem_ra       = AW'(idx_ff);

      if (csr_valid) attr_in = csr_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = mode_type'(req_tdata[1:0]);
               char_in     = req_tdata[9:2];
               idx_in      = req_tdata[20:10];
               scrolled_in = 1'b0;
               unique case (mode_type'(req_tdata[1:0]))
                  MODE_PUT:   state_in = ST_EXEC;
                  MODE_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  MODE_READ:  state_in = ST_READ;
                  MODE_NONE:  state_in = ST_DONE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_EXEC, ST_TAB: begin
            if (state_ff == ST_EXEC && char_ff >= CH_SPACE &&
                32'(row_ff) < ROWS && 32'(col_ff) < COLS) begin
               mem_we = 1'b1;
               mem_wa = AW'(row_ff * COLS + col_ff);
               mem_wd = {attr_ff, char_ff};
            end
            if (state_ff == ST_EXEC && char_ff == CH_TAB) begin
               acc_in   = CW'(TAB_STOP);
               state_in = ST_TAB;
            end else if (!fx_done) begin
               acc_in = acc_ff + CW'(TAB_STOP);
            end else begin
               col_in = wr_col;
               if (32'(wr_row) >= ROWS) begin
                  row_in      = RW'(ROWS - 1);
                  scrolled_in = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_COPY;
               end else begin
                  row_in   = wr_row;
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_COPY: begin
            // read one row below; the registered read is written back one row up
            mem_ra     = AW'(cnt_ff + COLS);
            cp_vld_in  = 1'b1;
            cp_addr_in = cnt_ff;
            if (32'(cnt_ff) == COPY_LAST) state_in = ST_DRAIN;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            cnt_in   = AW'(LAST_BASE);
            state_in = ST_FILL;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (32'(cnt_ff) == CELLS - 1) state_in = ST_DONE;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {scrolled_ff, out_data, 7'(col_ff), 5'(row_ff),
                               11'(row_ff * COLS + col_ff + 1)};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // pending copy write owns the port
      if (cp_vld_ff) begin
         mem_we = 1'b1;
         mem_wa = cp_addr_ff;
         mem_wd = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         cp_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         cp_vld_ff    <= cp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      cp_addr_ff  <= cp_addr_in;
      scrolled_ff <= scrolled_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_copy_not_in_fill: assert property (@(posedge clock) disable iff (reset)
      cp_vld_ff |-> state_ff != ST_FILL)
      else $error("copy write collides with fill write");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> 32'(row_ff) < ROWS)
      else $error("cursor row out of range while idle");

   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[39] |-> 32'(rsp_data_ff[15:11]) == ROWS - 1)
      else $error("scrolled response not on last row");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY || state_ff == ST_FILL |-> !req_tready)
      else $error("request accepted during full-screen pass");
`endif

endmodule

[verif/tb_top.sv]
// self-checking bench for the text console: streamed requests, predicted cursor and cell responses
module tb_top
   import tccs_pkg::*;
();

   localparam int NCELL = TCCS_ROWS * TCCS_COLS;

   // packed so the layout matches rsp_tdata, scrolled in the top bit
   typedef struct packed {
      logic        scrolled;
      logic [15:0] cell_data;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] pos;
   } console_rsp_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic [10:0] cell_index;
      logic [7:0]  char_code;
      mode_type    mode;
   } console_req_type;

   typedef struct {
      console_req_type req;
      console_rsp_type rsp;
   } console_job_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_data = '0;

   text_console_cursor_scroll_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #40000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // console shadow state
   logic [15:0]  screen_model [NCELL];
   bit           cell_written [NCELL];
   int           cur_row = 0;
   int           cur_col = 0;
   logic [7:0]   attr_model = ATTR_RESET;

   console_job_type pending_req_q [$];
   console_rsp_type rsp_expect_q [$];
   console_rsp_type held_rsp;

   int n_accepted = 0;
   int n_checked = 0;
   int mismatches = 0;
   int n_put = 0, n_clear = 0, n_read = 0, n_unused = 0, n_scroll = 0, n_attr = 0;
   int burst_left = 1;
   int gap_left = 0;
   bit hold_off = 1'b0;
   int rx_cycle = 0;

   function automatic console_rsp_type console_step(console_req_type rq);
      int r;
      int c;
      console_rsp_type o;
      r = cur_row;
      c = cur_col;
      o = '0;
      case (rq.mode)
         MODE_PUT: begin
            if (rq.char_code == CH_BS) begin
               if (c != 0) c--;
            end else if (rq.char_code == CH_TAB) begin
               c = c + TCCS_TAB_STOP - (c % TCCS_TAB_STOP);
            end else if (rq.char_code == CH_CR) begin
               c = 0;
            end else if (rq.char_code == CH_LF) begin
               c = 0;
               r++;
            end else if (rq.char_code >= CH_SPACE) begin
               screen_model[r * TCCS_COLS + c] = {attr_model, rq.char_code};
               cell_written[r * TCCS_COLS + c] = 1'b1;
               c++;
            end
            if (c >= TCCS_COLS) begin
               c = 0;
               r++;
            end
            // past the last row: shift everything up one line, blank the bottom
            if (r >= TCCS_ROWS) begin
               for (int i = 0; i < NCELL - TCCS_COLS; i++) begin
                  screen_model[i] = screen_model[i + TCCS_COLS];
                  cell_written[i] = cell_written[i + TCCS_COLS];
               end
               for (int i = NCELL - TCCS_COLS; i < NCELL; i++) begin
                  screen_model[i] = {attr_model, CH_SPACE};
                  cell_written[i] = 1'b1;
               end
               r = TCCS_ROWS - 1;
               o.scrolled = 1'b1;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < NCELL; i++) begin
               screen_model[i] = {attr_model, CH_SPACE};
               cell_written[i] = 1'b1;
            end
            r = 0;
            c = 0;
         end
         MODE_READ: begin
            if (rq.cell_index < NCELL) o.cell_data = screen_model[rq.cell_index];
         end
         default: ;
      endcase
      cur_row = r;
      cur_col = c;
      o.pos = 11'(r * TCCS_COLS + c + 1);
      o.row = 5'(r);
      o.col = 7'(c);
      return o;
   endfunction

   task automatic queue_request(mode_type m, logic [7:0] ch, logic [10:0] idx);
      console_job_type job;
      job.req = '{pad: 3'b000, cell_index: idx, char_code: ch, mode: m};
      job.rsp = console_step(job.req);
      case (m)
         MODE_PUT:   n_put++;
         MODE_CLEAR: n_clear++;
         MODE_READ:  n_read++;
         default:    n_unused++;
      endcase
      pending_req_q.push_back(job);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || rsp_expect_q.size() != 0);
   endtask

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 25) $display("mismatch on response %0d: %s", n_checked, msg);
   endtask

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin : req_driver
      console_job_type job;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            rsp_expect_q.push_back(held_rsp);
            n_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req_q.size() > 0) begin
               job = pending_req_q.pop_front();
               req_tdata <= REQ_W'(job.req);
               held_rsp = job.rsp;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // response monitor with its own stall pattern
   always @(posedge clock) begin : rsp_monitor
      console_rsp_type got;
      console_rsp_type want;
      logic ready_next;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = console_rsp_type'(rsp_tdata);
            if (rsp_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response 0x%0h", rsp_tdata));
            end else begin
               want = rsp_expect_q.pop_front();
               if (want.scrolled) n_scroll++;
               if (got.pos !== want.pos)
                  report_mismatch($sformatf("cursor_pos got %0d want %0d", got.pos, want.pos));
               if (got.row !== want.row)
                  report_mismatch($sformatf("cursor_row got %0d want %0d", got.row, want.row));
               if (got.col !== want.col)
                  report_mismatch($sformatf("cursor_col got %0d want %0d", got.col, want.col));
               if (got.cell_data !== want.cell_data)
                  report_mismatch($sformatf("cell_data got 0x%0h want 0x%0h",
                                            got.cell_data, want.cell_data));
               if (got.scrolled !== want.scrolled)
                  report_mismatch($sformatf("scrolled got %0d want %0d",
                                            got.scrolled, want.scrolled));
            end
            n_checked++;
         end
         rx_cycle++;
         case (rx_cycle[8:7])
            2'd0: ready_next = 1'b1;
            2'd1: ready_next = 1'($urandom_range(0, 1));
            2'd2: ready_next = (rx_cycle[1:0] == 2'd0);
            default: ready_next = ($urandom_range(0, 9) != 0);
         endcase
         rsp_tready <= ready_next && !hold_off;
      end
   end

   // long receiver hold-off so the block backs up into its request side
   initial begin
      int k;
      wait (n_accepted >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      for (k = 0; k < 400; k++) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      logic [7:0] attr_plan [6];
      logic [7:0] a;
      logic [7:0] ch;
      logic [10:0] idx;
      int w;
      int cnt;
      int cand;
      int target;
      attr_plan = '{8'h00, 8'hFF, 8'h3C, 8'h07, 8'hA5, 8'h00};
      do @(negedge clock); while (reset);

      // directed: reset attribute, blanks, read extremes, each put class
      queue_request(MODE_CLEAR, 8'h00, 11'd0);
      queue_request(MODE_READ, 8'hFF, 11'd0);
      queue_request(MODE_READ, 8'h00, 11'(NCELL - 1));
      queue_request(MODE_READ, 8'h00, 11'(NCELL));
      queue_request(MODE_READ, 8'h00, 11'h7FF);
      queue_request(MODE_PUT, 8'h41, 11'h7FF);
      queue_request(MODE_PUT, 8'hFF, 11'd0);
      queue_request(MODE_PUT, CH_SPACE, 11'd0);
      queue_request(MODE_PUT, 8'h00, 11'd0);
      queue_request(MODE_PUT, 8'h1F, 11'd0);
      queue_request(MODE_PUT, CH_BS, 11'd0);
      queue_request(MODE_PUT, CH_TAB, 11'd0);
      queue_request(MODE_PUT, CH_TAB, 11'd0);
      queue_request(MODE_PUT, CH_CR, 11'd0);
      // backspace at column 0 does nothing
      queue_request(MODE_PUT, CH_BS, 11'd0);
      queue_request(MODE_PUT, CH_LF, 11'd0);
      queue_request(MODE_NONE, 8'hFF, 11'h7FF);
      queue_request(MODE_READ, 8'h00, 11'd0);
      queue_request(MODE_READ, 8'h00, 11'd1);
      queue_request(MODE_PUT, 8'h7F, 11'd0);
      queue_request(MODE_READ, 8'h00, 11'(TCCS_COLS));

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         a = (ph == 2 || ph == 4) ? 8'($urandom) : attr_plan[ph];
         csr_valid <= 1'b1;
         csr_data <= a;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         attr_model = a;
         n_attr++;

         target = n_put + n_clear + n_read + n_unused + 125;
         while (n_put + n_clear + n_read + n_unused < target) begin
            w = $urandom_range(0, 999);
            idx = 11'($urandom_range(0, 2047));
            if (w < 350) begin
               cnt = $urandom_range(1, 16);
               repeat (cnt) queue_request(MODE_PUT, 8'($urandom_range(CH_SPACE, 255)), idx);
            end else if (w < 550) begin
               queue_request(MODE_PUT, CH_CR, idx);
               queue_request(MODE_PUT, CH_LF, idx);
            end else if (w < 620) begin
               queue_request(MODE_PUT, CH_LF, idx);
            end else if (w < 700) begin
               queue_request(MODE_PUT, CH_TAB, idx);
            end else if (w < 750) begin
               queue_request(MODE_PUT, CH_BS, idx);
            end else if (w < 780) begin
               queue_request(MODE_PUT, CH_CR, idx);
            end else if (w < 810) begin
               // control codes the console ignores
               do ch = 8'($urandom_range(0, 31));
               while (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
               queue_request(MODE_PUT, ch, idx);
            end else if (w < 980) begin
               cnt = $urandom_range(1, 3);
               repeat (cnt) begin
                  if ($urandom_range(0, 9) == 0) begin
                     idx = 11'($urandom_range(NCELL, 2047));
                  end else begin
                     // cells already set by a clear, a scroll or a write, else the out-of-range index NCELL
                     idx = 11'(NCELL);
                     for (int t = 0; t < 32; t++) begin
                        if ($urandom_range(0, 1) == 1)
                           cand = cur_row * TCCS_COLS + cur_col - $urandom_range(1, 12);
                        else
                           cand = $urandom_range(0, NCELL - 1);
                        if (cand >= 0 && cand < NCELL && cell_written[cand]) begin
                           idx = 11'(cand);
                           break;
                        end
                     end
                  end
                  queue_request(MODE_READ, 8'($urandom), idx);
               end
            end else if (w < 990) begin
               queue_request(MODE_NONE, 8'($urandom), idx);
            end else begin
               queue_request(MODE_CLEAR, 8'($urandom), idx);
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: %0d put, %0d clear, %0d read, %0d unused mode",
               n_checked, n_put, n_clear, n_read, n_unused);
      $display("%0d scrolls, %0d attribute writes, one long receiver hold-off",
               n_scroll, n_attr);
      if (mismatches == 0 && rsp_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
